@@ design/assert_macros.svh @@
// Assertion macros shared by the waypoint heading controller RTL.
// Simulation builds get concurrent assertions; builds with SYNTH defined get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define WHC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WHC_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WHC_ASSERT(label, clk, rst, prop, msg)
`define WHC_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

@@ design/whc_pkg.sv @@
// Types and constants of the waypoint heading controller.
// No dependencies; every module file refers to it by scoped names.
package whc_pkg;

   localparam int XY_W = 28;
   localparam int Z_W = 28;
   localparam int ERR_W = 18;
   localparam int MAX_STAGES = 20;

   localparam logic signed [Z_W-1:0] PI_Q24 = 28'sd52707179;
   localparam logic signed [Z_W-1:0] ROUND_HALF = 28'sd1024;
   localparam logic signed [ERR_W-1:0] PI_Q13 = 18'sd25736;
   localparam logic signed [ERR_W-1:0] TWO_PI_Q13 = 18'sd51472;

   localparam logic signed [Z_W-1:0] ATAN_TAB [MAX_STAGES] = '{
      28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
      28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768,
      28'sd16384, 28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024,
      28'sd512, 28'sd256, 28'sd128, 28'sd64, 28'sd32
   };

   localparam logic [2:0] REG_WAYPOINT_0 = 3'd0;
   localparam logic [2:0] REG_WAYPOINT_1 = 3'd1;
   localparam logic [2:0] REG_WAYPOINT_2 = 3'd2;
   localparam logic [2:0] REG_WAYPOINT_3 = 3'd3;
   localparam logic [2:0] REG_TURN_THRESHOLD = 3'd4;
   localparam logic [2:0] REG_TURN_RATE = 3'd5;
   localparam logic [2:0] REG_FORWARD_SPEED = 3'd6;
   localparam logic [2:0] REG_ARRIVAL_RADIUS = 3'd7;

   typedef struct packed {
      logic [3:0][31:0] waypoint;
      logic [14:0] turn_threshold;
      logic [14:0] turn_rate;
      logic [14:0] forward_speed;
      logic [14:0] arrival_radius;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      waypoint: '{3: 32'd0, 2: 32'd5120, 1: 32'd1006638080, 0: 32'd1006632960},
      turn_threshold: 15'd3277,
      turn_rate: 15'd1229,
      forward_speed: 15'd38,
      arrival_radius: 15'd256
   };

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0] z;
      logic zero;
      logic signed [15:0] heading;
      logic [1:0] target;
      logic arrive;
   } stage_type;

endpackage

@@ design/whc_cordic_cell.sv @@
// One CORDIC vectoring micro-rotation with its pipeline register.
// Depends on whc_pkg for the stage record and the arctangent table.
module whc_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic in_valid,
   input  whc_pkg::stage_type in_data,
   output logic out_valid,
   output whc_pkg::stage_type out_data
);

   logic valid_ff, valid_in;
   whc_pkg::stage_type data_ff, data_in;
   logic signed [whc_pkg::XY_W-1:0] x_shift, y_shift;
   logic y_positive;

   always_comb begin
      x_shift = in_data.x >>> STAGE;
      y_shift = in_data.y >>> STAGE;
      y_positive = !in_data.y[whc_pkg::XY_W-1] && (in_data.y != '0);
      data_in = in_data;
      if (y_positive) begin
         data_in.x = in_data.x + y_shift;
         data_in.y = in_data.y - x_shift;
         data_in.z = in_data.z + whc_pkg::ATAN_TAB[STAGE];
      end else begin
         data_in.x = in_data.x - y_shift;
         data_in.y = in_data.y + x_shift;
         data_in.z = in_data.z - whc_pkg::ATAN_TAB[STAGE];
      end
      valid_in = advance ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

@@ design/whc_front.sv @@
// Front stage: waypoint selection, arrival tests, target update and CORDIC pre-rotation.
// Depends on whc_pkg for the configuration and stage records.
module whc_front #(
   parameter int NUM_POINTS = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic req_valid,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_heading,
   input  whc_pkg::cfg_type cfg,
   output logic out_valid,
   output whc_pkg::stage_type out_data
);

   localparam logic [1:0] FINAL_IDX = 2'(NUM_POINTS - 1);

   logic [1:0] target_ff, target_in;
   logic done_ff, done_in;
   logic valid_ff, valid_in;
   whc_pkg::stage_type data_ff, data_in;

   logic [31:0] wpt, wpt_final;
   logic signed [16:0] dx, dy, fdx, fdy;
   logic signed [33:0] sq_x, sq_y;
   logic [33:0] dist_sq;
   logic [29:0] radius_sq;
   logic [16:0] abs_fdx, abs_fdy;
   logic [1:0] next_target;
   logic reached, near, arrive, take;
   logic signed [whc_pkg::XY_W-1:0] x_scaled, y_scaled;

   always_comb begin
      wpt = cfg.waypoint[target_ff];
      wpt_final = cfg.waypoint[FINAL_IDX];
      dx = $signed({wpt[31], wpt[31:16]}) - $signed({req_pos_x[15], req_pos_x});
      dy = $signed({wpt[15], wpt[15:0]}) - $signed({req_pos_y[15], req_pos_y});
      fdx = $signed({req_pos_x[15], req_pos_x}) - $signed({wpt_final[31], wpt_final[31:16]});
      fdy = $signed({req_pos_y[15], req_pos_y}) - $signed({wpt_final[15], wpt_final[15:0]});

      sq_x = dx * dx;
      sq_y = dy * dy;
      dist_sq = $unsigned(sq_x) + $unsigned(sq_y);
      radius_sq = cfg.arrival_radius * cfg.arrival_radius;
      reached = dist_sq < {4'b0, radius_sq};
      next_target = (reached && (target_ff != FINAL_IDX)) ? target_ff + 2'd1 : target_ff;

      abs_fdx = fdx[16] ? 17'(-fdx) : 17'(fdx);
      abs_fdy = fdy[16] ? 17'(-fdy) : 17'(fdy);
      near = (abs_fdx < {2'b0, cfg.arrival_radius}) && (abs_fdy < {2'b0, cfg.arrival_radius});
      arrive = (next_target == FINAL_IDX) && near;

      take = req_valid && advance && !done_ff;
      target_in = take ? next_target : target_ff;
      done_in = done_ff || (take && arrive);
      valid_in = advance ? (req_valid && !done_ff) : valid_ff;

      x_scaled = {{3{dx[16]}}, dx, 8'b0};
      y_scaled = {{3{dy[16]}}, dy, 8'b0};
      data_in.zero = (dx == '0) && (dy == '0);
      data_in.heading = req_heading;
      data_in.target = next_target;
      data_in.arrive = arrive;
      if (dx[16]) begin
         data_in.x = -x_scaled;
         data_in.y = -y_scaled;
         data_in.z = dy[16] ? -whc_pkg::PI_Q24 : whc_pkg::PI_Q24;
      end else begin
         data_in.x = x_scaled;
         data_in.y = y_scaled;
         data_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= 2'd0;
         done_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         target_ff <= target_in;
         done_ff <= done_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

@@ design/whc_out.sv @@
// Back end: bearing rounding, heading error wrap, turn decision and the result register.
// Depends on whc_pkg and on assert_macros.svh for its checks.
`include "assert_macros.svh"

module whc_out (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  whc_pkg::stage_type in_data,
   input  whc_pkg::cfg_type cfg,
   output logic advance,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [14:0] rsp_linear_cmd,
   output logic signed [15:0] rsp_angular_cmd,
   output logic [1:0] rsp_target_index,
   output logic rsp_finished,
   output logic rsp_last
);

   localparam int ERR_W = whc_pkg::ERR_W;

   logic err_valid_ff, err_valid_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic [1:0] err_target_ff, err_target_in;
   logic err_arrive_ff, err_arrive_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [14:0] rsp_linear_cmd_ff, rsp_linear_cmd_in;
   logic signed [15:0] rsp_angular_cmd_ff, rsp_angular_cmd_in;
   logic [1:0] rsp_target_index_ff, rsp_target_index_in;
   logic rsp_finished_ff, rsp_finished_in;
   logic rsp_last_ff, rsp_last_in;
   logic fin_pend_ff, fin_pend_in;

   logic signed [whc_pkg::Z_W-1:0] z_round;
   logic signed [16:0] bearing;
   logic signed [ERR_W-1:0] err_raw;
   logic [ERR_W-1:0] err_abs;
   logic signed [15:0] turn;
   logic out_free;

   always_comb begin
      z_round = in_data.z + whc_pkg::ROUND_HALF;
      bearing = in_data.zero ? 17'sd0 : z_round[whc_pkg::Z_W-1:11];
      err_raw = ERR_W'(bearing) - ERR_W'(in_data.heading);
      if (err_raw > whc_pkg::PI_Q13) begin
         err_in = err_raw - whc_pkg::TWO_PI_Q13;
      end else if (err_raw < -whc_pkg::PI_Q13) begin
         err_in = err_raw + whc_pkg::TWO_PI_Q13;
      end else begin
         err_in = err_raw;
      end
      err_target_in = in_data.target;
      err_arrive_in = in_data.arrive;

      out_free = !rsp_valid_ff || !rsp_stall;
      advance = out_free && !fin_pend_ff;
      err_valid_in = advance ? in_valid : err_valid_ff;

      err_abs = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : ERR_W'(err_ff);
      if (err_abs < {3'b0, cfg.turn_threshold}) begin
         turn = 16'sd0;
      end else if (!err_ff[ERR_W-1]) begin
         turn = $signed({1'b0, cfg.turn_rate});
      end else begin
         turn = -$signed({1'b0, cfg.turn_rate});
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_linear_cmd_in = rsp_linear_cmd_ff;
      rsp_angular_cmd_in = rsp_angular_cmd_ff;
      rsp_target_index_in = rsp_target_index_ff;
      rsp_finished_in = rsp_finished_ff;
      rsp_last_in = rsp_last_ff;
      fin_pend_in = fin_pend_ff;
      if (fin_pend_ff) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_linear_cmd_in = '0;
            rsp_angular_cmd_in = '0;
            rsp_finished_in = 1'b1;
            rsp_last_in = 1'b1;
            fin_pend_in = 1'b0;
         end
      end else if (advance) begin
         rsp_valid_in = err_valid_ff;
         rsp_linear_cmd_in = cfg.forward_speed;
         rsp_angular_cmd_in = turn;
         rsp_target_index_in = err_target_ff;
         rsp_finished_in = 1'b0;
         rsp_last_in = !err_arrive_ff;
         fin_pend_in = err_valid_ff && err_arrive_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fin_pend_ff <= 1'b0;
      end else begin
         err_valid_ff <= err_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fin_pend_ff <= fin_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         err_ff <= err_in;
         err_target_ff <= err_target_in;
         err_arrive_ff <= err_arrive_in;
      end
      rsp_linear_cmd_ff <= rsp_linear_cmd_in;
      rsp_angular_cmd_ff <= rsp_angular_cmd_in;
      rsp_target_index_ff <= rsp_target_index_in;
      rsp_finished_ff <= rsp_finished_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_linear_cmd = rsp_linear_cmd_ff;
   assign rsp_angular_cmd = rsp_angular_cmd_ff;
   assign rsp_target_index = rsp_target_index_ff;
   assign rsp_finished = rsp_finished_ff;
   assign rsp_last = rsp_last_ff;

   `WHC_ASSERT(a_pend_holds_first, clock, reset, fin_pend_ff |-> rsp_valid_ff && !rsp_last_ff, "stop pending without a held driving result")
   `WHC_ASSERT(a_stop_follows, clock, reset, rsp_valid_ff && !rsp_last_ff && !rsp_stall |=> rsp_valid_ff && rsp_finished_ff, "stop result did not follow the arrival result")
   `WHC_ASSERT(a_silent_after_stop, clock, reset, rsp_valid_ff && rsp_finished_ff && !rsp_stall |=> !rsp_valid_ff && !err_valid_ff, "result produced after the stop command")

endmodule

@@ design/waypoint_heading_controller.sv @@
// Top level of the waypoint heading controller: configuration registers and the CORDIC chain.
// Depends on whc_pkg, whc_front, whc_cordic_cell and whc_out.
//
// The controller accepts one pose request per clock cycle while it is not
// stalled and answers it through a chain of registers: the front stage,
// where the waypoint index is updated so that the next request already sees
// the new target, one register in each cell of the unrolled CORDIC chain,
// the heading error wrap register and the result register. The request that
// reaches the final waypoint yields two results, a driving command and then
// the finished stop command; from then on requests are accepted and dropped
// until reset. A stalled result holds the whole pipeline, so requests are
// stalled for as long as the result side is.
module waypoint_heading_controller #(
   parameter int NUM_POINTS = 4,
   parameter int CORDIC_STAGES = 14
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_heading,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [14:0] rsp_linear_cmd,
   output logic signed [15:0] rsp_angular_cmd,
   output logic [1:0] rsp_target_index,
   output logic rsp_finished,
   output logic rsp_last,
   input  logic csr_we,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_data
);

   whc_pkg::cfg_type cfg_ff, cfg_in;
   logic advance;
   logic [CORDIC_STAGES:0] chain_valid;
   whc_pkg::stage_type chain_data [CORDIC_STAGES+1];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            whc_pkg::REG_WAYPOINT_0: begin
               cfg_in.waypoint[0] = csr_data;
            end
            whc_pkg::REG_WAYPOINT_1: begin
               cfg_in.waypoint[1] = csr_data;
            end
            whc_pkg::REG_WAYPOINT_2: begin
               cfg_in.waypoint[2] = csr_data;
            end
            whc_pkg::REG_WAYPOINT_3: begin
               cfg_in.waypoint[3] = csr_data;
            end
            whc_pkg::REG_TURN_THRESHOLD: begin
               cfg_in.turn_threshold = csr_data[14:0];
            end
            whc_pkg::REG_TURN_RATE: begin
               cfg_in.turn_rate = csr_data[14:0];
            end
            whc_pkg::REG_FORWARD_SPEED: begin
               cfg_in.forward_speed = csr_data[14:0];
            end
            whc_pkg::REG_ARRIVAL_RADIUS: begin
               cfg_in.arrival_radius = csr_data[14:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= whc_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = !advance;

   whc_front #(
      .NUM_POINTS(NUM_POINTS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .req_valid(req_valid),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_heading(req_heading),
      .cfg(cfg_ff),
      .out_valid(chain_valid[0]),
      .out_data(chain_data[0])
   );

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      whc_cordic_cell #(
         .STAGE(g)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .advance(advance),
         .in_valid(chain_valid[g]),
         .in_data(chain_data[g]),
         .out_valid(chain_valid[g+1]),
         .out_data(chain_data[g+1])
      );
   end

   whc_out u_out (
      .clock(clock),
      .reset(reset),
      .in_valid(chain_valid[CORDIC_STAGES]),
      .in_data(chain_data[CORDIC_STAGES]),
      .cfg(cfg_ff),
      .advance(advance),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_linear_cmd(rsp_linear_cmd),
      .rsp_angular_cmd(rsp_angular_cmd),
      .rsp_target_index(rsp_target_index),
      .rsp_finished(rsp_finished),
      .rsp_last(rsp_last)
   );

endmodule
